@@ hdl/kmp_pkg.sv @@
// Shared types and constants for the KMP substring matcher.
package kmp_pkg;

   localparam int SYMBOL_W      = 8;
   localparam int MATCH_START_W = 32;

   typedef logic [SYMBOL_W-1:0]      symbol_type;
   typedef logic [MATCH_START_W-1:0] match_start_type;

   // Item kind carried in the op field.
   localparam logic OP_PATTERN = 1'b0;
   localparam logic OP_TEXT    = 1'b1;

endpackage

@@ hdl/kmp_channels.sv @@
// Valid/ready channel interfaces for the matcher's request and response transactions.
interface kmp_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   kmp_pkg::symbol_type  symbol;
   logic                 restart;

   modport source (output valid, output op, output symbol, output restart, input ready);
   modport sink   (input valid, input op, input symbol, input restart, output ready);
endinterface

interface kmp_rsp_if;
   logic                      valid;
   logic                      ready;
   kmp_pkg::match_start_type  match_start;

   modport source (output valid, output match_start, input ready);
   modport sink   (input valid, input match_start, output ready);
endinterface

@@ hdl/kmp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module kmp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/kmp_substring_matcher_core.sv @@
// KMP substring matcher: online failure-table build and streaming text search, one item at a time.
// Pattern byte: done in idle for the first byte or once the store is full, else goes through PLINK
// and CMP, CMP repeating per failure link followed. Text byte: done in idle with an empty pattern,
// else goes through CMP (repeating per link) and TDONE, plus FLINK on a full match, TDONE waiting
// until an earlier result is accepted; the link walk is bounded by the current matched length.
// Synchronous reset clears lengths, text position and the response; the RAMs are not cleared.
module kmp_substring_matcher_core #(
   parameter int PATTERN_MAX   = 64,
   parameter int POSITION_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   kmp_req_if.sink    req_chan,
   kmp_rsp_if.source  rsp_chan
);
   import kmp_pkg::*;

   localparam int ADDR_W = $clog2(PATTERN_MAX);
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam int POS_W  = POSITION_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PLINK,
      S_CMP,
      S_TDONE,
      S_FLINK
   } state_type;

   state_type         state_ff;
   logic [LEN_W-1:0]  plen_ff;
   logic [LEN_W-1:0]  mlen_ff;
   logic [LEN_W-1:0]  k_ff;
   logic [POS_W-1:0]  pos_ff;
   symbol_type        sym_ff;
   logic              mode_ff;
   logic              out_valid_ff;
   match_start_type   match_start_ff;

   logic              req_fire;
   logic              rsp_fire;
   logic [LEN_W-1:0]  plen_eff;
   logic [LEN_W-1:0]  mlen_eff;
   logic [LEN_W-1:0]  k_start;
   logic [LEN_W-1:0]  seek_k;
   logic [LEN_W-1:0]  k_done;
   logic              hit;
   logic              cmp_done;
   logic [POS_W-1:0]  pos_eff;
   logic [POS_W-1:0]  start_pos;

   logic              pat_we;
   logic [ADDR_W-1:0] pat_wa;
   logic [ADDR_W-1:0] pat_ra;
   symbol_type        pat_rd;
   logic              fail_we;
   logic [ADDR_W-1:0] fail_wa;
   logic [ADDR_W-1:0] fail_wd;
   logic [ADDR_W-1:0] fail_ra;
   logic [ADDR_W-1:0] fail_rd;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign req_fire             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.match_start = match_start_ff;
   assign rsp_fire             = out_valid_ff && rsp_chan.ready;

   assign plen_eff = req_chan.restart ? '0 : plen_ff;
   assign mlen_eff = req_chan.restart ? '0 : mlen_ff;
   assign pos_eff  = req_chan.restart ? '0 : pos_ff;
   assign k_start  = (mlen_eff >= plen_ff) ? '0 : mlen_eff;

   // Shared compare unit: stored pattern byte against the byte in work.
   assign hit      = (pat_rd == sym_ff);
   assign cmp_done = hit || (k_ff == '0);
   assign k_done   = hit ? LEN_W'(k_ff + 1'b1) : k_ff;

   assign start_pos = POS_W'(pos_ff + POS_W'(1) - POS_W'(plen_ff));

   // RAM control: next prefix length to probe and the writes.
   always_comb begin
      seek_k  = k_ff;
      fail_ra = ADDR_W'(k_ff - 1'b1);
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.op == OP_TEXT) begin
               seek_k  = k_start;
               fail_ra = ADDR_W'(k_start - 1'b1);
            end else begin
               fail_ra = ADDR_W'(plen_eff - 1'b1);
            end
         end
         S_PLINK: begin
            seek_k  = LEN_W'(fail_rd);
            fail_ra = ADDR_W'(fail_rd - 1'b1);
         end
         S_CMP: begin
            if (!cmp_done) begin
               seek_k  = LEN_W'(fail_rd);
               fail_ra = ADDR_W'(fail_rd - 1'b1);
            end
         end
         S_TDONE: begin
            fail_ra = ADDR_W'(plen_ff - 1'b1);
         end
         default: begin
            seek_k  = k_ff;
         end
      endcase
      pat_ra = seek_k[ADDR_W-1:0];

      pat_we  = req_fire && (req_chan.op == OP_PATTERN) &&
                (plen_eff < LEN_W'(PATTERN_MAX));
      pat_wa  = plen_eff[ADDR_W-1:0];
      fail_we = 1'b0;
      fail_wa = plen_ff[ADDR_W-1:0];
      fail_wd = k_done[ADDR_W-1:0];
      if (pat_we && (plen_eff == '0)) begin
         fail_we = 1'b1;
         fail_wa = '0;
         fail_wd = '0;
      end else if ((state_ff == S_CMP) && cmp_done && (mode_ff == OP_PATTERN)) begin
         fail_we = 1'b1;
      end
   end

   kmp_ram #(.WIDTH(SYMBOL_W), .DEPTH(PATTERN_MAX)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_wa),
      .wr_data (req_chan.symbol),
      .rd_addr (pat_ra),
      .rd_data (pat_rd)
   );

   kmp_ram #(.WIDTH(ADDR_W), .DEPTH(PATTERN_MAX)) u_failure_ram (
      .clock   (clock),
      .wr_en   (fail_we),
      .wr_addr (fail_wa),
      .wr_data (fail_wd),
      .rd_addr (fail_ra),
      .rd_data (fail_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plen_ff      <= '0;
         mlen_ff      <= '0;
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // Drop the accepted result unless a new one loads in this cycle.
         if (rsp_fire && !((state_ff == S_TDONE) && (k_ff == plen_ff))) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  sym_ff  <= req_chan.symbol;
                  mode_ff <= req_chan.op;
                  if (req_chan.op == OP_PATTERN) begin
                     if (req_chan.restart) begin
                        plen_ff <= '0;
                        mlen_ff <= '0;
                     end
                     if (plen_eff == '0) begin
                        plen_ff <= LEN_W'(1);
                     end else if (plen_eff < LEN_W'(PATTERN_MAX)) begin
                        state_ff <= S_PLINK;
                     end
                  end else begin
                     mlen_ff <= mlen_eff;
                     if (plen_ff == '0) begin
                        pos_ff <= POS_W'(pos_eff + 1'b1);
                     end else begin
                        pos_ff   <= pos_eff;
                        k_ff     <= k_start;
                        state_ff <= S_CMP;
                     end
                  end
               end
            end
            S_PLINK: begin
               k_ff     <= seek_k;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (cmp_done) begin
                  if (mode_ff == OP_PATTERN) begin
                     plen_ff  <= LEN_W'(plen_ff + 1'b1);
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_done;
                     state_ff <= S_TDONE;
                  end
               end else begin
                  // Mismatch: follow the failure link and probe again.
                  k_ff <= seek_k;
               end
            end
            S_TDONE: begin
               if (k_ff == plen_ff) begin
                  // Hold until the response register is free.
                  if (!out_valid_ff || rsp_chan.ready) begin
                     out_valid_ff   <= 1'b1;
                     match_start_ff <= MATCH_START_W'(start_pos);
                     state_ff       <= S_FLINK;
                  end
               end else begin
                  mlen_ff  <= k_ff;
                  pos_ff   <= POS_W'(pos_ff + 1'b1);
                  state_ff <= S_IDLE;
               end
            end
            S_FLINK: begin
               mlen_ff  <= LEN_W'(fail_rd);
               pos_ff   <= POS_W'(pos_ff + 1'b1);
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ hdl/kmp_checker.sv @@
// Port-level assertions for the KMP matcher, bound to the top level.
module kmp_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  kmp_pkg::match_start_type match_start
);
   import kmp_pkg::*;

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(match_start))
      else $error("response changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A result is never loaded straight from the accepted request; it comes from later matcher states.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("response appeared one cycle after a request");

   // Results are loaded only while a text item is in work.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response loaded while idle");

endmodule

bind kmp_substring_matcher_core kmp_checker u_kmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .match_start (rsp_chan.match_start)
);
